// File: rtl/sbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the source byte tokenizer
// Token kind codes, the token item record and the token group that the
// scanner hands to the output queue.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // Widths of the token fields on the output channel
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned FIELD_W = 16;

  // Most tokens that one source byte can produce
  localparam int unsigned GROUP_MAX = 3;
  localparam int unsigned COUNT_W   = $clog2(GROUP_MAX + 1);

  // Depth of the token group queue
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT  = 4'd0,
    KIND_INT    = 4'd1,
    KIND_STRING = 4'd2,
    KIND_ASSIGN = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_DOT    = 4'd6,
    KIND_PLUS   = 4'd7,
    KIND_MINUS  = 4'd8,
    KIND_STAR   = 4'd9,
    KIND_SLASH  = 4'd10,
    KIND_SEMI   = 4'd11,
    KIND_UNTERM = 4'd12,
    KIND_END    = 4'd13
  } token_kind_e;

  // One token as it leaves the block
  typedef struct packed {
    token_kind_e        kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
  } token_t;

  // Tokens caused by one source byte, packed from slot 0 upward
  typedef struct packed {
    logic [COUNT_W-1:0]          count;
    token_t [GROUP_MAX-1:0]      tokens;
  } token_group_t;

  // Handshake between scanner and output queue
  typedef struct packed {
    logic         push;
    token_group_t group;
  } group_push_t;

endpackage

// File: rtl/sbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_if: stream channels of the source byte tokenizer
// Byte channel into the block and token channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_final;

  modport source (output valid, byte_value, is_final, input ready);
  modport sink (input valid, byte_value, is_final, output ready);
endinterface

interface sbt_out_if import sbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [FIELD_W-1:0] start_offset;
  logic [FIELD_W-1:0] token_length;
  logic [FIELD_W-1:0] line_number;
  logic               last_result;

  modport source (output valid, token_kind, start_offset, token_length, line_number,
                  last_result, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, line_number,
                last_result, output ready);
endinterface

// File: rtl/source_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer: streaming lexical analyzer
// Scans source bytes and emits tokens with kind, start offset, length and
// line number.
// ----------------------------------------------------------------------------
// The block accepts one source byte per clock cycle whenever the queue has a
// free entry. Each byte is scanned in the cycle it is taken and produces
// zero to three tokens, which go as one group into a four-entry queue; the
// output side delivers one token per cycle from the head of that queue while
// the sink is ready. A token stream of up to one token per byte thus runs at
// one byte per cycle; bytes that end several tokens at once (a final byte, or
// a byte that both closes an identifier and is punctuation) take one output
// transfer per token. Offset and line count saturate at 2^OFFSET_BITS - 1 and
// are reported in their low 16 bits. After the final byte all state returns
// to its reset values and the next byte opens a new text.
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbt_in_if.sink    in_i,
  sbt_out_if.source out_o
);

  group_push_t push;
  logic        queue_ready;
  token_t      token;
  logic        last;

  // Scan and classify incoming bytes
  sbt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .byte_value_i  (in_i.byte_value),
    .is_final_i    (in_i.is_final),
    .queue_ready_i (queue_ready),
    .push_o        (push)
  );

  // Queue token groups and serialize them onto the output
  sbt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (queue_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .token_o (token),
    .last_o  (last)
  );

  assign out_o.token_kind   = token.kind;
  assign out_o.start_offset = token.start;
  assign out_o.token_length = token.length;
  assign out_o.line_number  = token.line;
  assign out_o.last_result  = last;

endmodule

// File: rtl/sbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_front: byte scanner
// Classifies each source byte, keeps offset, line count and scan mode, and
// builds, combinationally, the group of tokens that the byte completes.
// ----------------------------------------------------------------------------
module sbt_front import sbt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        is_final_i,
  input  logic        queue_ready_i,
  output group_push_t push_o
);

  localparam int unsigned OB = OFFSET_BITS;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } scan_mode_e;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
    return (v == {OB{1'b1}}) ? v : v + {{(OB-1){1'b0}}, 1'b1};
  endfunction

  // Fit an offset-wide value onto a 16-bit output field
  function automatic logic [FIELD_W-1:0] to_field(input logic [OB-1:0] v);
    logic [OB+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, v};
    return ext[FIELD_W-1:0];
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  scan_mode_e      mode_q, mode_d;
  logic [OB-1:0]   pos_q, pos_d;
  logic [OB-1:0]   start_q, start_d;
  logic [OB-1:0]   line_q, line_d;

  logic            fire;
  logic [OB-1:0]   end_pos;
  logic            consumed;
  logic            punct_hit;
  token_kind_e     punct_kind;
  logic            flush_v, mid_v;
  token_t          flush_tok, mid_tok, end_tok;
  logic [GROUP_MAX-1:0] cand_v;
  token_t [GROUP_MAX-1:0] cand;
  token_group_t    group;
  logic [COUNT_W-1:0] fill;

  assign fire    = valid_i && ready_o;
  assign ready_o = queue_ready_i;
  assign end_pos = sat_inc(pos_q);

  // Decode single-character punctuation
  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = KIND_ASSIGN;
    unique case (byte_value_i)
      8'h3D:   punct_kind = KIND_ASSIGN;
      8'h28:   punct_kind = KIND_LPAREN;
      8'h29:   punct_kind = KIND_RPAREN;
      8'h2E:   punct_kind = KIND_DOT;
      8'h2B:   punct_kind = KIND_PLUS;
      8'h2D:   punct_kind = KIND_MINUS;
      8'h2A:   punct_kind = KIND_STAR;
      8'h2F:   punct_kind = KIND_SLASH;
      8'h3B:   punct_kind = KIND_SEMI;
      default: punct_hit = 1'b0;
    endcase
  end

  // Scan the byte: advance state and collect the tokens it ends
  always_comb begin
    mode_d    = mode_q;
    start_d   = start_q;
    line_d    = line_q;
    pos_d     = end_pos;
    consumed  = 1'b0;
    flush_v   = 1'b0;
    mid_v     = 1'b0;
    flush_tok = '{kind: KIND_IDENT, start: to_field(start_q),
                  length: to_field(pos_q - start_q), line: to_field(line_q)};
    mid_tok   = flush_tok;

    if (mode_q == MODE_STRING) begin
      if (byte_value_i == CH_QUOTE) begin
        flush_v          = 1'b1;
        flush_tok.kind   = KIND_STRING;
        flush_tok.length = to_field(end_pos - start_q);
        mode_d           = MODE_IDLE;
      end else if (byte_value_i == CH_LF) begin
        line_d = sat_inc(line_q);
      end
    end else begin
      // Close a pending identifier or number on a byte that cannot extend it
      if (mode_q == MODE_IDENT) begin
        if (is_letter(byte_value_i) || is_digit(byte_value_i)) begin
          consumed = 1'b1;
        end else begin
          flush_v = 1'b1;
          mode_d  = MODE_IDLE;
        end
      end else if (mode_q == MODE_NUMBER) begin
        if (is_digit(byte_value_i)) begin
          consumed = 1'b1;
        end else begin
          flush_v        = 1'b1;
          flush_tok.kind = KIND_INT;
          mode_d         = MODE_IDLE;
        end
      end
      // Scan the byte as in idle mode
      if (!consumed) begin
        if (byte_value_i == CH_LF) begin
          line_d = sat_inc(line_q);
        end else if (punct_hit) begin
          mid_v   = 1'b1;
          mid_tok = '{kind: punct_kind, start: to_field(pos_q),
                      length: to_field(end_pos - pos_q), line: to_field(line_q)};
        end else if (byte_value_i == CH_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = pos_q;
        end else if (is_letter(byte_value_i)) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
        end else if (is_digit(byte_value_i)) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
        end
        // Tab, space, CR and any other byte fall through with no token
      end
    end

    end_tok = '{kind: KIND_END, start: to_field(end_pos), length: '0,
                line: to_field(line_d)};

    // Flush what the last byte leaves pending, then restart the text
    if (is_final_i) begin
      if (mode_d != MODE_IDLE) begin
        mid_v   = 1'b1;
        mid_tok = '{kind: KIND_IDENT, start: to_field(start_d),
                    length: to_field(end_pos - start_d), line: to_field(line_d)};
        if (mode_d == MODE_NUMBER) begin
          mid_tok.kind = KIND_INT;
        end else if (mode_d == MODE_STRING) begin
          mid_tok.kind = KIND_UNTERM;
        end
      end
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      line_d  = '0;
    end
  end

  // Pack the candidate tokens in order into the group
  always_comb begin
    cand_v = {is_final_i, mid_v, flush_v};
    cand   = {end_tok, mid_tok, flush_tok};
    group  = '0;
    fill   = '0;
    for (int i = 0; i < GROUP_MAX; i++) begin
      if (cand_v[i]) begin
        group.tokens[fill] = cand[i];
        fill               = fill + 1'b1;
      end
    end
    group.count = fill;
  end

  assign push_o.push  = fire && (fill != '0);
  assign push_o.group = group;

  // Hold scanner state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
    end
  end

endmodule

// File: rtl/sbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_back: token group queue and output serializer
// Buffers token groups from the scanner and delivers their tokens one per
// transaction on the output channel.
// ----------------------------------------------------------------------------
module sbt_back import sbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  group_push_t        push_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output token_t             token_o,
  output logic               last_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  token_group_t       store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COUNT_W-1:0] idx_q, idx_d;

  token_group_t       head;
  logic               out_fire;
  logic               pop;
  logic               push;

  assign ready_o  = (cnt_q != FULL);
  assign push     = push_i.push && ready_o;
  assign head     = store_q[rd_q];
  assign valid_o  = (cnt_q != '0);
  assign token_o  = head.tokens[idx_q[$clog2(GROUP_MAX)-1:0]];
  assign last_o   = (token_o.kind == KIND_END);
  assign out_fire = valid_o && ready_i;
  assign pop      = out_fire && ((idx_q + 1'b1) == head.count);

  // Advance pointers, fill count and token index
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    idx_d = idx_q;
    if (pop) begin
      idx_d = '0;
    end else if (out_fire) begin
      idx_d = idx_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Write the incoming group into its slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_q] <= push_i.group;
    end
  end

endmodule

// File: tb/sv/token_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_checker: token predictor and comparator for the tokenizer
// Watches the byte and token channels. It scans every accepted source byte
// with its own tokenizer model, queues the tokens that byte should produce,
// and compares each accepted output token field by field against the oldest
// queued token.
// ----------------------------------------------------------------------------
module token_stream_checker import sbt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbt_in_if           in_mon,
  sbt_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned tokens_pending
);

  localparam longint unsigned POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam int unsigned MAX_PRINTED = 30;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING
  } scan_mode_e;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_record_t;

  scan_mode_e      scan_mode;
  longint unsigned byte_pos;
  longint unsigned tok_start;
  longint unsigned line_count;
  token_record_t   expected_tokens[$];

  function automatic longint unsigned sat_inc(longint unsigned v);
    return (v >= POS_MAX) ? POS_MAX : v + 64'd1;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Map a single-character punctuation byte to its token kind
  function automatic bit punct_lookup(input logic [7:0] b, output token_kind_e k);
    k = KIND_END;
    case (b)
      "=": k = KIND_ASSIGN;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      ".": k = KIND_DOT;
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "*": k = KIND_STAR;
      "/": k = KIND_SLASH;
      ";": k = KIND_SEMI;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic queue_token(token_kind_e k, longint unsigned st, longint unsigned len,
                             longint unsigned ln, logic last);
    token_record_t r;
    r.tok.kind   = k;
    r.tok.start  = FIELD_W'(st);
    r.tok.length = FIELD_W'(len);
    r.tok.line   = FIELD_W'(ln);
    r.last       = last;
    expected_tokens.push_back(r);
  endtask

  task automatic clear_scan();
    scan_mode  = SCAN_IDLE;
    byte_pos   = 0;
    tok_start  = 0;
    line_count = 0;
  endtask

  // Advance the scanner by one source byte and queue the tokens it ends
  task automatic scan_byte(logic [7:0] b, logic fin);
    longint unsigned endp;
    bit              consumed;
    token_kind_e     pk;
    endp     = sat_inc(byte_pos);
    consumed = 1'b0;
    if (scan_mode == SCAN_STRING) begin
      if (b == CH_QUOTE) begin
        queue_token(KIND_STRING, tok_start, endp - tok_start, line_count, 1'b0);
        scan_mode = SCAN_IDLE;
      end else if (b == CH_LF) begin
        line_count = sat_inc(line_count);
      end
    end else begin
      // A pending word either absorbs the byte or is closed by it
      if (scan_mode == SCAN_IDENT) begin
        if (is_letter(b) || is_digit(b)) begin
          consumed = 1'b1;
        end else begin
          queue_token(KIND_IDENT, tok_start, byte_pos - tok_start, line_count, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end else if (scan_mode == SCAN_NUMBER) begin
        if (is_digit(b)) begin
          consumed = 1'b1;
        end else begin
          queue_token(KIND_INT, tok_start, byte_pos - tok_start, line_count, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end
      if (!consumed) begin
        if (b == CH_LF) begin
          line_count = sat_inc(line_count);
        end else if (punct_lookup(b, pk)) begin
          queue_token(pk, byte_pos, endp - byte_pos, line_count, 1'b0);
        end else if (b == CH_QUOTE) begin
          scan_mode = SCAN_STRING;
          tok_start = byte_pos;
        end else if (is_letter(b)) begin
          scan_mode = SCAN_IDENT;
          tok_start = byte_pos;
        end else if (is_digit(b)) begin
          scan_mode = SCAN_NUMBER;
          tok_start = byte_pos;
        end
      end
    end
    byte_pos = endp;

    // Flush the pending token, close the text and start over
    if (fin) begin
      case (scan_mode)
        SCAN_IDENT:  queue_token(KIND_IDENT, tok_start, endp - tok_start, line_count, 1'b0);
        SCAN_NUMBER: queue_token(KIND_INT, tok_start, endp - tok_start, line_count, 1'b0);
        SCAN_STRING: queue_token(KIND_UNTERM, tok_start, endp - tok_start, line_count, 1'b0);
        default: ;
      endcase
      queue_token(KIND_END, endp, 0, line_count, 1'b1);
      clear_scan();
    end
  endtask

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Compare one output transaction against the oldest expected token
  task automatic check_token();
    token_record_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d line %0d",
                                out_mon.token_kind, out_mon.start_offset,
                                out_mon.token_length, out_mon.line_number));
    end else begin
      want = expected_tokens.pop_front();
      if (out_mon.token_kind !== want.tok.kind)
        report_mismatch($sformatf("kind got %0d want %0d", out_mon.token_kind,
                                  want.tok.kind));
      if (out_mon.start_offset !== want.tok.start)
        report_mismatch($sformatf("start got %0d want %0d", out_mon.start_offset,
                                  want.tok.start));
      if (out_mon.token_length !== want.tok.length)
        report_mismatch($sformatf("length got %0d want %0d", out_mon.token_length,
                                  want.tok.length));
      if (out_mon.line_number !== want.tok.line)
        report_mismatch($sformatf("line got %0d want %0d", out_mon.line_number,
                                  want.tok.line));
      if (out_mon.last_result !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", out_mon.last_result,
                                  want.last));
    end
  endtask

  // Scan accepted bytes first; a token from this edge's byte cannot leave yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      fail_count = 0;
      tokens_pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        scan_byte(in_mon.byte_value, in_mon.is_final);
      end
      if (out_mon.valid && out_mon.ready) begin
        check_token();
      end
      tokens_pending <= expected_tokens.size();
    end
  end

endmodule

// File: tb/sv/source_byte_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer_tb: testbench top of the source byte tokenizer
// Feeds short hand-written texts, then random token-shaped texts with noise.
// Both channels idle at random; a separate checker predicts every token.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_tb;
  import sbt_pkg::*;

  localparam int unsigned OFFSET_BITS  = 16;
  localparam longint      CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 230;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned tokens_pending;
  longint      cycle_count;
  logic [7:0]  text_bytes[$];
  string       punct_chars = "=().+-*/;";

  sbt_in_if  in_bus ();
  sbt_out_if out_bus ();

  source_byte_tokenizer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  token_stream_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .tokens_pending(tokens_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] off;
    off = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) != 0) ? "a" + off : "A" + off;
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return "\t";
      2: return "\r";
      default: return "\n";
    endcase
  endfunction

  // Any byte but a double quote, mostly printable, sometimes LF
  function automatic logic [7:0] rand_string_char();
    logic [7:0] v;
    case ($urandom_range(0, 15))
      0, 1: v = "\n";
      2: v = 8'($urandom_range(0, 255));
      default: v = 8'($urandom_range(32, 126));
    endcase
    if (v == "\"") v = "#";
    return v;
  endfunction

  task automatic add_chars(string s);
    foreach (s[i]) text_bytes.push_back(s[i]);
  endtask

  // Build one text from well-formed tokens, with noise and open strings mixed in
  task automatic build_random_text();
    int unsigned n_tokens;
    n_tokens = $urandom_range(1, 12);
    repeat (n_tokens) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          text_bytes.push_back(rand_letter());
          repeat ($urandom_range(0, 6)) begin
            text_bytes.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
          end
        end
        3, 4: repeat ($urandom_range(1, 5)) text_bytes.push_back(rand_digit());
        5: begin
          text_bytes.push_back("\"");
          repeat ($urandom_range(0, 6)) text_bytes.push_back(rand_string_char());
          if ($urandom_range(0, 9) != 0) text_bytes.push_back("\"");
        end
        6, 7: text_bytes.push_back(punct_chars[$urandom_range(0, 8)]);
        8, 9: text_bytes.push_back(rand_space());
        10: text_bytes.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) text_bytes.push_back(rand_space());
    end
    if (text_bytes.size() == 0) text_bytes.push_back(rand_letter());
  endtask

  // Send the queued text; the last byte carries the end-of-text flag
  task automatic send_text(bit use_gaps);
    int unsigned g;
    foreach (text_bytes[i]) begin
      g = use_gaps ? gap_len() : 0;
      if (g > 0) begin
        in_bus.valid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      in_bus.valid      <= 1'b1;
      in_bus.byte_value <= text_bytes[i];
      in_bus.is_final   <= (i == text_bytes.size() - 1);
      do @(posedge clk_i); while (!in_bus.ready);
    end
    text_bytes.delete();
  endtask

  // Token sink: bursts of ready with random stalls between them
  initial begin
    int unsigned run_len;
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_bus.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Byte source: directed texts, then random texts
  initial begin
    int unsigned sent;
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.byte_value <= 8'h00;
    in_bus.is_final   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Word closed by punctuation on the last byte: three tokens at once
    add_chars("Zz0)");
    send_text(1'b1);
    // Number closed by a letter, word closed by punctuation, every punctuation but ')'
    add_chars("9a=.-*/(+;");
    send_text(1'b1);
    // Skipped whitespace, dropped extreme bytes, empty string ending the text
    add_chars("\t\r ");
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h00);
    add_chars("\n\"\"");
    send_text(1'b1);
    // String left open at the end of the text, with a newline inside
    add_chars("\"q\n");
    send_text(1'b0);

    // Random texts until enough bytes have gone in
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_random_text();
      sent += text_bytes.size();
      send_text($urandom_range(0, 4) != 0);
    end
    in_bus.valid <= 1'b0;

    // Let the last byte reach the pending count, drain, then watch for strays
    @(posedge clk_i);
    while (tokens_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: source_byte_tokenizer.f
rtl/sbt_pkg.sv
rtl/sbt_if.sv
rtl/sbt_front.sv
rtl/sbt_back.sv
rtl/source_byte_tokenizer.sv
tb/sv/token_stream_checker.sv
tb/sv/source_byte_tokenizer_tb.sv
